// ===== design/hrfw_pkg.sv =====
package hrfw_pkg;

  // field widths
  localparam int CHAR_W     = 8;
  localparam int POS_W      = 10;
  localparam int COUNT_W    = 8;
  localparam int ADDR_LO_W  = 16;
  localparam int UPPER_W    = 16;
  localparam int INDEX_W    = 7;
  localparam int DIGIT_W    = 4;
  localparam int HOLD_W     = 12;
  localparam int HALF_W     = 16;
  localparam int FLASH_W    = 32;

  // configuration port
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam int REG_SEL_BIT = 2;

  typedef enum logic {
    REG_UPPER_ADDRESS = 1'b0
  } reg_idx_e;

  localparam logic [UPPER_W-1:0] UPPER_RESET = 16'h0801;

  // character positions within a record
  localparam logic [POS_W-1:0] POS_START      = 10'd0;
  localparam logic [POS_W-1:0] POS_COUNT_HI   = 10'd1;
  localparam logic [POS_W-1:0] POS_COUNT_LO   = 10'd2;
  localparam logic [POS_W-1:0] POS_ADDR_FIRST = 10'd3;
  localparam logic [POS_W-1:0] POS_ADDR_LAST  = 10'd6;
  localparam logic [POS_W-1:0] POS_KIND       = 10'd8;
  localparam logic [POS_W-1:0] POS_DATA       = 10'd9;
  localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'd57;
  localparam logic [CHAR_W-1:0] ALPHA_BIAS  = 8'd55;
  localparam logic [CHAR_W-1:0] KIND_DATA   = 8'd48;

  // group slot of the last digit of a halfword
  localparam logic [1:0] SLOT_LAST = 2'd3;

  // one accepted character
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              start;
  } item_t;

  // one decoded halfword, valid when a result is produced
  typedef struct packed {
    logic               valid;
    logic [FLASH_W-1:0] addr;
    logic [HALF_W-1:0]  hw;
    logic               last;
  } result_t;

  // ascii hex digit, lenient: anything that is not 0-9 wraps through the letter bias
  function automatic logic [DIGIT_W-1:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    diff = c - ALPHA_BIAS;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return c[DIGIT_W-1:0];
    end
    return diff[DIGIT_W-1:0];
  endfunction

endpackage

// ===== design/hrfw_in_stage.sv =====
module hrfw_in_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [hrfw_pkg::CHAR_W-1:0]       record_char_i,
  input  logic                              record_start_i,
  input  logic                              advance_i,
  output logic                              in_stall_o,
  output logic                              item_valid_o,
  output hrfw_pkg::item_t                   item_o
);
  import hrfw_pkg::*;

  logic  valid_q, valid_d;
  logic  load;
  item_t item_q;

  // hold the item while the result side is blocked
  assign in_stall_o = valid_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !advance_i);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{ch: record_char_i, start: record_start_i};
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/hrfw_record_decode.sv =====
module hrfw_record_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  input  logic                              advance_i,
  input  hrfw_pkg::item_t                   item_i,
  input  logic [hrfw_pkg::UPPER_W-1:0]      upper_address_i,
  output hrfw_pkg::result_t                 result_o
);
  import hrfw_pkg::*;

  logic [POS_W-1:0]     char_position_q, char_position_d;
  logic [COUNT_W-1:0]   byte_count_q, byte_count_d;
  logic [ADDR_LO_W-1:0] address_low_q, address_low_d;
  logic                 is_data_q, is_data_d;
  logic [HOLD_W-1:0]    digit_hold_q, digit_hold_d;
  logic [INDEX_W-1:0]   hw_index_q, hw_index_d;

  logic                 step;
  logic [POS_W-1:0]     pos;
  logic [DIGIT_W-1:0]   digit;
  logic [INDEX_W-1:0]   total;
  logic [1:0]           slot;
  logic                 in_payload;
  logic [INDEX_W:0]     index_plus;
  logic [FLASH_W-1:0]   base;

  assign step  = item_valid_i && advance_i;
  assign pos   = item_i.start ? POS_START : char_position_q;
  assign digit = hex_digit(item_i.ch);
  assign total = byte_count_q[COUNT_W-1:1];
  // data groups start at position nine, so the slot is offset by one
  assign slot  = pos[1:0] - 2'd1;
  assign in_payload = is_data_q && (hw_index_q < total);
  assign index_plus = {1'b0, hw_index_q} + {{INDEX_W{1'b0}}, 1'b1};
  assign base  = {upper_address_i, address_low_q};

  // per-character state update and halfword assembly
  always_comb begin
    char_position_d = (pos < POS_MAX) ? pos + 10'd1 : POS_MAX;
    byte_count_d    = byte_count_q;
    address_low_d   = address_low_q;
    is_data_d       = is_data_q;
    digit_hold_d    = digit_hold_q;
    hw_index_d      = hw_index_q;
    result_o        = '{valid: 1'b0,
                        addr:  base + {{(FLASH_W-INDEX_W-1){1'b0}}, hw_index_q, 1'b0},
                        hw:    {digit_hold_q[3:0], digit, digit_hold_q[11:8],
                                digit_hold_q[7:4]},
                        last:  index_plus == {1'b0, total}};
    priority if (pos == POS_START) begin
      is_data_d  = 1'b0;
      hw_index_d = '0;
    end else if (pos == POS_COUNT_HI) begin
      byte_count_d = {digit, 4'd0};
    end else if (pos == POS_COUNT_LO) begin
      byte_count_d = {byte_count_q[7:4], digit};
    end else if (pos == POS_ADDR_FIRST) begin
      address_low_d = {12'd0, digit};
    end else if (pos <= POS_ADDR_LAST) begin
      address_low_d = {address_low_q[11:0], digit};
    end else if (pos == POS_KIND) begin
      is_data_d  = (item_i.ch == KIND_DATA);
      hw_index_d = '0;
    end else if (pos >= POS_DATA && in_payload) begin
      if (slot == SLOT_LAST) begin
        result_o.valid = step;
        hw_index_d     = index_plus[INDEX_W-1:0];
      end else begin
        digit_hold_d = {digit_hold_q[7:0], digit};
      end
    end else begin
      // separator or ignored trailing characters
      hw_index_d = hw_index_q;
    end
  end

  // record state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_position_q <= '0;
      byte_count_q    <= '0;
      address_low_q   <= '0;
      is_data_q       <= 1'b0;
      digit_hold_q    <= '0;
      hw_index_q      <= '0;
    end else if (step) begin
      char_position_q <= char_position_d;
      byte_count_q    <= byte_count_d;
      address_low_q   <= address_low_d;
      is_data_q       <= is_data_d;
      digit_hold_q    <= digit_hold_d;
      hw_index_q      <= hw_index_d;
    end
  end

endmodule

// ===== design/hrfw_out_stage.sv =====
module hrfw_out_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  hrfw_pkg::result_t                 result_i,
  input  logic                              out_stall_i,
  output logic                              advance_o,
  output logic                              out_valid_o,
  output logic [hrfw_pkg::FLASH_W-1:0]      flash_address_o,
  output logic [hrfw_pkg::HALF_W-1:0]       halfword_o,
  output logic                              last_of_record_o
);
  import hrfw_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // the result register frees up when empty or when its item is taken
  assign advance_o = !(valid_q && out_stall_i);
  assign valid_d   = advance_o ? result_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && result_i.valid) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign flash_address_o  = res_q.addr;
  assign halfword_o       = res_q.hw;
  assign last_of_record_o = res_q.last;

endmodule

// ===== design/hex_record_flash_writer.sv =====
// Hex record flash writer: takes one ASCII hex record character per cycle
// unless stalled (record_start_i flags the leading colon) and returns one
// item per data halfword, carrying its flash byte address (upper_address
// register in bits 31:16, record load address plus twice the halfword index
// below) and a flag on the record's final halfword. Non-data records, byte
// counts under two and odd trailing bytes give no items; the checksum is
// not checked. Throughput is one character per cycle while in_stall_o is
// low; an accepted character passes through the input register and the
// decode into the result register. in_stall_o rises only while a result
// is held by out_stall_i. Write upper_address only while idle.
module hex_record_flash_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hrfw_pkg::CHAR_W-1:0]       record_char_i,
  input  logic                              record_start_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hrfw_pkg::FLASH_W-1:0]      flash_address_o,
  output logic [hrfw_pkg::HALF_W-1:0]       halfword_o,
  output logic                              last_of_record_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrfw_pkg::PADDR_W-1:0]      paddr,
  input  logic [hrfw_pkg::PDATA_W-1:0]      pwdata,
  output logic [hrfw_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import hrfw_pkg::*;

  logic [UPPER_W-1:0] upper_q;
  reg_idx_e           reg_idx;
  logic               cfg_write;
  logic               advance;
  logic               item_valid;
  item_t              item;
  result_t            result;

  // configuration register
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[REG_SEL_BIT]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= UPPER_RESET;
    end else if (cfg_write && reg_idx == REG_UPPER_ADDRESS) begin
      upper_q <= pwdata[UPPER_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_UPPER_ADDRESS) ?
                  {{(PDATA_W-UPPER_W){1'b0}}, upper_q} : '0;

  // input register
  hrfw_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .record_char_i (record_char_i),
    .record_start_i(record_start_i),
    .advance_i     (advance),
    .in_stall_o    (in_stall_o),
    .item_valid_o  (item_valid),
    .item_o        (item)
  );

  // record decode and state
  hrfw_record_decode u_dec (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .advance_i      (advance),
    .item_i         (item),
    .upper_address_i(upper_q),
    .result_o       (result)
  );

  // result register
  hrfw_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .result_i        (result),
    .out_stall_i     (out_stall_i),
    .advance_o       (advance),
    .out_valid_o     (out_valid_o),
    .flash_address_o (flash_address_o),
    .halfword_o      (halfword_o),
    .last_of_record_o(last_of_record_o)
  );

endmodule

// ===== design/hrfw_checker.sv =====
module hrfw_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic [hrfw_pkg::CHAR_W-1:0]       record_char_i,
  input  logic                              record_start_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic [hrfw_pkg::FLASH_W-1:0]      flash_address_o,
  input  logic [hrfw_pkg::HALF_W-1:0]       halfword_o,
  input  logic                              last_of_record_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrfw_pkg::PADDR_W-1:0]      paddr,
  input  logic [hrfw_pkg::PDATA_W-1:0]      pwdata,
  input  logic [hrfw_pkg::PDATA_W-1:0]      prdata,
  input  logic                              pready
);
  import hrfw_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flash_address_o)
      && $stable(halfword_o) && $stable(last_of_record_o))
    else $error("result item changed while stalled");

  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no result held");

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

  // register read back follows the last write
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[REG_SEL_BIT] == REG_UPPER_ADDRESS)
      ##1 (paddr[REG_SEL_BIT] == REG_UPPER_ADDRESS)
      |-> prdata[UPPER_W-1:0] == $past(pwdata[UPPER_W-1:0]))
    else $error("upper address read back mismatch");

endmodule

bind hex_record_flash_writer hrfw_checker u_hrfw_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrfw_pkg::*;

  localparam int  CLK_PERIOD       = 10;
  localparam int  RESET_CYCLES     = 10;
  localparam int  PHASES           = 5;
  localparam int  RANDOM_ITEMS     = 800;
  localparam int  SETTLE_CYCLES    = 8;
  localparam int  LONG_HOLD_CYCLES = 300;
  localparam int  REPORT_LINES     = 60;
  localparam int  UNUSED_REG_INDEX = 1;
  localparam int  DIRECTED_ROWS    = 26;
  localparam logic [CHAR_W-1:0] COLON   = 8'h3A;
  localparam logic [CHAR_W-1:0] UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] LOWER_A = 8'h61;

  // one decoded halfword as it leaves the block
  typedef struct packed {
    logic [FLASH_W-1:0] addr;
    logic [HALF_W-1:0]  hw;
    logic               last;
  } halfword_rec_t;

  // one directed character with its hand-written outcome
  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               start;
    logic               has_res;
    logic [FLASH_W-1:0] addr;
    logic [HALF_W-1:0]  hw;
    logic               last;
  } table_row_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [CHAR_W-1:0]    record_char_i  = '0;
  logic                 record_start_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [FLASH_W-1:0]   flash_address_o;
  logic [HALF_W-1:0]    halfword_o;
  logic                 last_of_record_o;
  logic                 psel           = 1'b0;
  logic                 penable        = 1'b0;
  logic                 pwrite         = 1'b0;
  logic [PADDR_W-1:0]   paddr          = '0;
  logic [PDATA_W-1:0]   pwdata         = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  hex_record_flash_writer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .record_char_i    (record_char_i),
    .record_start_i   (record_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .flash_address_o  (flash_address_o),
    .halfword_o       (halfword_o),
    .last_of_record_o (last_of_record_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // decoder state mirrored by the predictor
  logic [UPPER_W-1:0]   m_upper   = UPPER_RESET;
  logic [POS_W-1:0]     m_pos     = '0;
  logic [COUNT_W-1:0]   m_count   = '0;
  logic [ADDR_LO_W-1:0] m_addr_lo = '0;
  logic                 m_is_data = 1'b0;
  logic [HOLD_W-1:0]    m_hold    = '0;
  logic [INDEX_W-1:0]   m_index   = '0;

  halfword_rec_t pending_halfwords[$];

  int  mismatches     = 0;
  int  chars_sent     = 0;
  int  records_sent   = 0;
  int  halfwords_seen = 0;
  int  settings_made  = 0;
  int  long_holds     = 0;
  bit  quiet          = 1'b0;
  bit  long_hold_req  = 1'b0;

  // directed characters: a record after reset without a start flag, then a
  // non-data record with lower-case digits and extreme character codes
  table_row_t directed_rows [DIRECTED_ROWS] = '{
    '{COLON, 1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"0",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"2",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"E",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"0",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"0",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"0",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"A",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"9",   1'b0, 1'b1, 32'h0801_FFFE, 16'hA9F0, 1'b1},
    '{8'h00, 1'b1, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"0",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"3",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"a",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"b",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"c",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"d",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"1",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0},
    '{"F",   1'b0, 1'b0, 32'h0, 16'h0, 1'b0}
  };

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < REPORT_LINES) begin
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  // advance the decoder by one character, return the halfword it completes
  task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic start,
                              output bit made, output halfword_rec_t res);
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] nib;
    logic [CHAR_W-1:0]  biased;
    logic [INDEX_W-1:0] total;
    logic [1:0]         slot;
    pos    = start ? POS_START : m_pos;
    biased = ch - ALPHA_BIAS;
    nib    = (ch >= CHAR_ZERO && ch <= CHAR_NINE) ? DIGIT_W'(ch - CHAR_ZERO)
                                                   : biased[DIGIT_W-1:0];
    total  = m_count[COUNT_W-1:1];
    slot   = 2'(pos - POS_DATA);
    made   = 1'b0;
    res    = '0;
    if (pos == POS_START) begin
      m_is_data = 1'b0;
      m_index   = '0;
    end else if (pos == POS_COUNT_HI) begin
      m_count = {nib, 4'h0};
    end else if (pos == POS_COUNT_LO) begin
      m_count[3:0] = nib;
    end else if (pos == POS_ADDR_FIRST) begin
      m_addr_lo = ADDR_LO_W'(nib);
    end else if (pos > POS_ADDR_FIRST && pos <= POS_ADDR_LAST) begin
      m_addr_lo = {m_addr_lo[ADDR_LO_W-DIGIT_W-1:0], nib};
    end else if (pos == POS_KIND) begin
      m_is_data = (ch == KIND_DATA);
      m_index   = '0;
    end else if (pos >= POS_DATA && m_is_data && m_index < total) begin
      if (slot != SLOT_LAST) begin
        m_hold = {m_hold[HOLD_W-DIGIT_W-1:0], nib};
      end else begin
        // first byte low, digits swapped into place
        res.addr = {m_upper, m_addr_lo} + FLASH_W'({m_index, 1'b0});
        res.hw   = {m_hold[3:0], nib, m_hold[11:8], m_hold[7:4]};
        res.last = (m_index + 1'b1 == total);
        m_index  = m_index + 1'b1;
        made     = 1'b1;
      end
    end
    m_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
  endtask

  // offer one character and wait for it to be taken
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic start,
                           input bit from_table, input table_row_t row);
    int            gap;
    bit            made;
    halfword_rec_t res;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    record_char_i  <= ch;
    record_start_i <= start;
    do @(posedge clk_i); while (in_stall_o);
    predict_char(ch, start, made, res);
    if (from_table) begin
      if (row.has_res) pending_halfwords.push_back({row.addr, row.hw, row.last});
    end else if (made) begin
      pending_halfwords.push_back(res);
    end
    chars_sent++;
  endtask

  // apb setup and access cycles, then the bus is released
  task automatic apb_access(input bit wr, input int idx, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(idx << REG_SEL_BIT);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_upper();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, int'(REG_UPPER_ADDRESS), '0, rd);
    if (rd[UPPER_W-1:0] !== m_upper) report_mismatch("upper_address readback", rd, m_upper);
  endtask

  task automatic set_upper(input logic [UPPER_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, int'(REG_UPPER_ADDRESS), PDATA_W'(value), rd);
    m_upper = value;
    settings_made++;
    check_upper();
  endtask

  // a write to an address with no register must leave upper_address alone
  task automatic write_unused(input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    apb_access(1'b1, UNUSED_REG_INDEX, value, rd);
    check_upper();
  endtask

  // wait until every halfword is out and the pipeline is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_halfwords.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] hex_char(input logic [DIGIT_W-1:0] nib, input bit lax);
    if (lax && $urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(0, 255));
    if (nib < 10) return CHAR_ZERO + CHAR_W'(nib);
    return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + CHAR_W'(nib - 10);
  endfunction

  task automatic send_noise(input int n, input bit with_starts);
    int i;
    for (i = 0; i < n; i++) begin
      send_char(CHAR_W'($urandom_range(0, 255)), with_starts && $urandom_range(0, 3) == 0,
                1'b0, '0);
    end
  endtask

  // build one record, optionally cut short after a number of characters
  task automatic send_record(input logic [COUNT_W-1:0] count, input logic [ADDR_LO_W-1:0] addr,
                             input logic [CHAR_W-1:0] kind, input bit lax, input int cut);
    logic [CHAR_W-1:0] line[$];
    int                n;
    int                i;
    line.push_back(($urandom_range(0, 7) == 0) ? CHAR_W'($urandom_range(0, 255)) : COLON);
    line.push_back(hex_char(count[7:4], lax));
    line.push_back(hex_char(count[3:0], lax));
    line.push_back(hex_char(addr[15:12], lax));
    line.push_back(hex_char(addr[11:8], lax));
    line.push_back(hex_char(addr[7:4], lax));
    line.push_back(hex_char(addr[3:0], lax));
    line.push_back(CHAR_W'($urandom_range(0, 255)));
    line.push_back(kind);
    // data bytes then the checksum pair
    for (i = 0; i < 2 * int'(count) + 2; i++) begin
      line.push_back(hex_char(DIGIT_W'($urandom_range(0, 15)), lax));
    end
    n = (cut > 0 && cut < line.size()) ? cut : line.size();
    for (i = 0; i < n; i++) send_char(line[i], i == 0, 1'b0, '0);
    records_sent++;
  endtask

  // mostly well-formed data records, some broken ones and noise
  task automatic send_random_record();
    int                 r;
    logic [COUNT_W-1:0] count;
    logic [ADDR_LO_W-1:0] addr;
    logic [CHAR_W-1:0]  kind;
    bit                 lax;
    int                 cut;
    r     = $urandom_range(0, 99);
    count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(17, 64))
                                        : COUNT_W'($urandom_range(2, 16));
    addr  = ($urandom_range(0, 3) == 0) ? {8'hFF, 8'($urandom)} : ADDR_LO_W'($urandom);
    kind  = KIND_DATA;
    lax   = 1'b0;
    cut   = 0;
    if (r < 70) begin
      lax = 1'b0;
    end else if (r < 78) begin
      kind = CHAR_W'($urandom_range(0, 255));
      if (kind == KIND_DATA) kind = KIND_DATA + 1'b1;
    end else if (r < 84) begin
      count = COUNT_W'($urandom_range(0, 1));
    end else if (r < 92) begin
      cut = $urandom_range(1, 9 + 2 * int'(count));
    end else if (r < 97) begin
      lax = 1'b1;
    end else begin
      send_noise($urandom_range(1, 6), 1'b1);
      return;
    end
    send_record(count, addr, kind, lax, cut);
  endtask

  // receiver: a random hold-off before each item, one long one on request
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_holds++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare every accepted halfword with the oldest prediction
  always @(posedge clk_i) begin
    halfword_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_halfwords.size() == 0) begin
        report_mismatch("unexpected result at", flash_address_o, '0);
      end else begin
        want = pending_halfwords.pop_front();
        halfwords_seen++;
        if (flash_address_o !== want.addr)
          report_mismatch("flash_address", flash_address_o, want.addr);
        if (halfword_o !== want.hw)
          report_mismatch("halfword", 32'(halfword_o), 32'(want.hw));
        if (last_of_record_o !== want.last)
          report_mismatch("last_of_record", 32'(last_of_record_o), 32'(want.last));
      end
    end
  end

  // stimulus
  initial begin
    logic [UPPER_W-1:0] phase_upper [PHASES];
    int                 p;
    int                 i;
    int                 phase_start;
    phase_upper = '{16'h0000, 16'hFFFF, UPPER_W'($urandom), UPPER_W'($urandom), UPPER_RESET};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_upper();

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_char(directed_rows[i].ch, directed_rows[i].start, 1'b1, directed_rows[i]);
    end

    for (p = 0; p < PHASES; p++) begin
      settle();
      if (p == 2) write_unused(PDATA_W'($urandom));
      set_upper(phase_upper[p]);
      quiet = (p == 3);
      if (p == 1) long_hold_req = 1'b1;
      // longest record, then characters on past the position limit
      if (p == 2) begin
        send_record(8'hFF, ADDR_LO_W'($urandom), KIND_DATA, 1'b0, 0);
        send_noise(POS_MAX - 500, 1'b0);
      end
      phase_start = chars_sent;
      while (chars_sent - phase_start < RANDOM_ITEMS / PHASES) send_random_record();
    end

    settle();
    if (pending_halfwords.size() != 0)
      report_mismatch("leftover expectations", pending_halfwords.size(), 0);
    $display("covered %0d characters in %0d random records, %0d halfwords compared",
             chars_sent, records_sent, halfwords_seen);
    $display("%0d upper address settings, %0d long receiver hold-offs",
             settings_made, long_holds);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
design/hrfw_pkg.sv
design/hrfw_in_stage.sv
design/hrfw_record_decode.sv
design/hrfw_out_stage.sv
design/hex_record_flash_writer.sv
design/hrfw_checker.sv
dv/testbench.sv
